/* rtl/pmfb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers of the paged monochrome frame buffer.
// Used by every module of the block but pmfb_blit; depends on nothing else.
package pmfb_pkg;

  localparam int COLUMNS     = 84;
  localparam int ROWS        = 48;
  localparam int PAGES       = (ROWS + 7) / 8;
  localparam int STORE_BYTES = PAGES * COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    MODE_PIXEL = 3'd0,
    MODE_FILL  = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_BLIT  = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic       pixel_value;
    logic [7:0] blit_width;
    logic [7:0] blit_height;
    logic       blit_start;
    logic [8:0] byte_index;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [8:0] index;
  } result_t;

  // First byte of a page: page * COLUMNS.
  function automatic logic [15:0] page_base(input logic [4:0] page);
    page_base = 16'(int'(page) * COLUMNS);
  endfunction

endpackage

/* rtl/pmfb_store.sv */
`timescale 1ns / 1ps
// Frame store: one write port and one registered read port.
// Depends on pmfb_pkg for the store size and the request type.
module pmfb_store (
  input  logic                clk,
  input  pmfb_pkg::mem_req_t  req,
  output logic [7:0]          rdata
);

  logic [7:0] mem [pmfb_pkg::STORE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* rtl/pmfb_blit.sv */
`timescale 1ns / 1ps
// Blit position counters: column and row offset of the next image pixel.
// Self-contained; depends on no other file of the block.
module pmfb_blit (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       start,
  input  logic [7:0] width,
  input  logic [7:0] height,
  output logic [7:0] col_off,
  output logic [7:0] row_off
);

  logic [7:0] col;
  logic [7:0] row;
  logic [8:0] row_inc;
  logic [8:0] col_inc;

  // A start pixel sees the counters at zero.
  assign col_off = start ? 8'd0 : col;
  assign row_off = start ? 8'd0 : row;
  assign row_inc = {1'b0, row_off} + 9'd1;
  assign col_inc = {1'b0, col_off} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= 8'd0;
      row <= 8'd0;
    end else if (step) begin
      if (row_inc >= {1'b0, height}) begin
        row <= 8'd0;
        col <= (col_inc >= {1'b0, width}) ? 8'd0 : col_inc[7:0];
      end else begin
        row <= row_inc[7:0];
        col <= col_off;
      end
    end
  end

endmodule

/* rtl/pmfb_ctrl.sv */
`timescale 1ns / 1ps
// Command sequencer: read-modify-write of store bytes, rectangle walk,
// clearing pass and read-back. Depends on pmfb_pkg.
module pmfb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pmfb_pkg::item_t             item,
  input  logic [7:0]                  col_off,
  input  logic [7:0]                  row_off,
  output logic                        blit_step,
  output pmfb_pkg::mem_req_t          req,
  input  logic [7:0]                  rdata,
  input  logic                        out_free,
  output pmfb_pkg::result_t           res
);

  localparam logic [pmfb_pkg::ADDR_W-1:0] LAST_ADDR =
    pmfb_pkg::ADDR_W'(pmfb_pkg::STORE_BYTES - 1);

  pmfb_pkg::state_t state, state_next;

  logic [pmfb_pkg::ADDR_W-1:0] clr_addr;
  logic [pmfb_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0]                  bit_mask;
  logic                        pv;
  logic [8:0]                  rd_index;
  logic                        rd_ok;
  logic [7:0]                  x_cur;
  logic [7:0]                  x_end;
  logic [4:0]                  pg_cur;
  logic [4:0]                  pg_first;
  logic [4:0]                  pg_last;
  logic [2:0]                  lo_bit;
  logic [2:0]                  hi_bit;

  logic                        accept;
  logic                        is_blit;
  logic [7:0]                  x_add;
  logic [7:0]                  y_add;
  logic [8:0]                  x9;
  logic [8:0]                  y9;
  logic                        pix_ok;
  logic [pmfb_pkg::ADDR_W-1:0] pix_addr;
  logic [7:0]                  xe;
  logic [7:0]                  ye;
  logic [7:0]                  ye_m1;
  logic                        fill_ok;
  logic [pmfb_pkg::ADDR_W-1:0] fill_addr;
  logic [2:0]                  lo_b;
  logic [2:0]                  hi_b;
  logic [7:0]                  fill_mask;
  logic                        fill_last;
  logic [7:0]                  x_nxt;

  assign accept  = in_valid && (state == pmfb_pkg::ST_IDLE);
  assign is_blit = (item.mode == pmfb_pkg::MODE_BLIT);

  // Pixel address; a blit pixel is offset by the image position.
  assign x_add    = is_blit ? col_off : 8'd0;
  assign y_add    = is_blit ? row_off : 8'd0;
  assign x9       = {1'b0, item.x_a} + {1'b0, x_add};
  assign y9       = {1'b0, item.y_a} + {1'b0, y_add};
  assign pix_ok   = (x9 < 9'(pmfb_pkg::COLUMNS)) && (y9 < 9'(pmfb_pkg::ROWS));
  assign pix_addr = pmfb_pkg::ADDR_W'(pmfb_pkg::page_base(y9[7:3]) + 16'(x9));

  // Rectangle clipped to the display.
  assign xe      = ({1'b0, item.x_b} > 9'(pmfb_pkg::COLUMNS)) ?
                   8'(pmfb_pkg::COLUMNS) : item.x_b;
  assign ye      = ({1'b0, item.y_b} > 9'(pmfb_pkg::ROWS)) ?
                   8'(pmfb_pkg::ROWS) : item.y_b;
  assign ye_m1   = ye - 8'd1;
  assign fill_ok = (item.x_a < xe) && (item.y_a < ye);

  assign fill_addr = pmfb_pkg::ADDR_W'(pmfb_pkg::page_base(pg_cur) + 16'(x_cur));
  assign lo_b      = (pg_cur == pg_first) ? lo_bit : 3'd0;
  assign hi_b      = (pg_cur == pg_last) ? hi_bit : 3'd7;
  assign fill_mask = (8'hFF << lo_b) & (8'hFF >> (3'd7 - hi_b));
  assign x_nxt     = x_cur + 8'd1;
  assign fill_last = (pg_cur == pg_last) && (x_nxt == x_end);

  always_comb begin
    state_next = state;
    unique case (state)
      pmfb_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = pmfb_pkg::ST_IDLE;
      end
      pmfb_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (item.mode) inside
            pmfb_pkg::MODE_PIXEL, pmfb_pkg::MODE_BLIT:
              state_next = pix_ok ? pmfb_pkg::ST_PIX_WR : pmfb_pkg::ST_IDLE;
            pmfb_pkg::MODE_FILL:
              state_next = fill_ok ? pmfb_pkg::ST_FILL_RD : pmfb_pkg::ST_IDLE;
            pmfb_pkg::MODE_CLEAR: state_next = pmfb_pkg::ST_CLEAR;
            pmfb_pkg::MODE_READ:  state_next = pmfb_pkg::ST_READ;
            default:              state_next = pmfb_pkg::ST_IDLE;
          endcase
        end
      end
      pmfb_pkg::ST_PIX_WR:  state_next = pmfb_pkg::ST_IDLE;
      pmfb_pkg::ST_FILL_RD: state_next = pmfb_pkg::ST_FILL_WR;
      pmfb_pkg::ST_FILL_WR: begin
        state_next = fill_last ? pmfb_pkg::ST_IDLE : pmfb_pkg::ST_FILL_RD;
      end
      pmfb_pkg::ST_READ: begin
        if (out_free) state_next = pmfb_pkg::ST_IDLE;
      end
      default: state_next = pmfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == pmfb_pkg::ST_IDLE);
    blit_step = accept && is_blit;
    req.we    = 1'b0;
    req.waddr = wr_addr;
    req.wdata = 8'd0;
    req.raddr = wr_addr;
    res.valid = 1'b0;
    res.data  = rd_ok ? rdata : 8'd0;
    res.index = rd_index;
    unique case (state)
      pmfb_pkg::ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_addr;
      end
      pmfb_pkg::ST_IDLE: begin
        req.raddr = (item.mode == pmfb_pkg::MODE_READ) ?
                    pmfb_pkg::ADDR_W'(item.byte_index) : pix_addr;
      end
      pmfb_pkg::ST_PIX_WR: begin
        req.we    = 1'b1;
        req.wdata = pv ? (rdata | bit_mask) : (rdata & ~bit_mask);
      end
      pmfb_pkg::ST_FILL_RD: begin
        req.raddr = fill_addr;
      end
      pmfb_pkg::ST_FILL_WR: begin
        req.we    = 1'b1;
        req.waddr = fill_addr;
        req.wdata = rdata | fill_mask;
      end
      pmfb_pkg::ST_READ: begin
        res.valid = out_free;
      end
      default: begin
        req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pmfb_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == pmfb_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else if (accept) begin
        clr_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr  <= (item.mode == pmfb_pkg::MODE_READ) ?
                  pmfb_pkg::ADDR_W'(item.byte_index) : pix_addr;
      bit_mask <= 8'd1 << y9[2:0];
      pv       <= item.pixel_value;
      rd_index <= item.byte_index;
      rd_ok    <= int'(item.byte_index) < pmfb_pkg::STORE_BYTES;
      x_cur    <= item.x_a;
      x_end    <= xe;
      pg_cur   <= item.y_a[7:3];
      pg_first <= item.y_a[7:3];
      pg_last  <= ye_m1[7:3];
      lo_bit   <= item.y_a[2:0];
      hi_bit   <= ye_m1[2:0];
    end else if (state == pmfb_pkg::ST_FILL_WR) begin
      if (pg_cur == pg_last) begin
        pg_cur <= pg_first;
        x_cur  <= x_nxt;
      end else begin
        pg_cur <= pg_cur + 5'd1;
      end
    end
  end

endmodule

/* rtl/paged_mono_frame_buffer_core.sv */
`timescale 1ns / 1ps
// Top level of the paged monochrome frame buffer: stream ports, result register.
// Depends on pmfb_pkg, pmfb_store, pmfb_blit and pmfb_ctrl.
//
// The block holds a one-bit-per-pixel image of COLUMNS x ROWS pixels (84 x 48
// by default) in a single-port-write, registered-read store of 504 bytes, laid
// out in pages of eight rows: pixel (x, y) is bit y%8 of byte (y/8)*COLUMNS+x.
// Each input word carries one command in tuser: write a pixel, fill a
// rectangle with ones, clear the store, place the next pixel of an image blit,
// or read one store byte; only a read returns a word on the output side.
// Pixels off the display are dropped. Commands are paced by the store's
// read-modify-write: a pixel write or blit pixel reads its byte when taken
// and writes it back in ST_PIX_WR (not at all if it falls off the display),
// a read waits for the output register to free up, a rectangle fill reads and
// writes back each byte touched (clipped columns times pages covered), and a
// clear zeroes all 504 bytes. After reset a clearing pass runs with tready low.
// The output register lets new commands enter while a read word waits.
module paged_mono_frame_buffer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: x_a[7:0], y_a[15:8], x_b[23:16], y_b[31:24],
  // pixel_value[32], blit_width[40:33], blit_height[48:41], blit_start[49],
  // byte_index[58:50], zero fill[63:59].
  input  logic [63:0] s_tdata,
  // s_tuser: mode[2:0].
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: read_byte[7:0], read_index[16:8], zero fill[23:17].
  output logic [23:0] m_tdata
);

  pmfb_pkg::item_t    item;
  pmfb_pkg::mem_req_t req;
  pmfb_pkg::result_t  res;
  logic [7:0]         rdata;
  logic [7:0]         col_off;
  logic [7:0]         row_off;
  logic               blit_step;
  logic               out_free;
  logic [7:0]         out_byte;
  logic [8:0]         out_index;

  // Unpack the command word.
  assign item.mode        = s_tuser;
  assign item.x_a         = s_tdata[7:0];
  assign item.y_a         = s_tdata[15:8];
  assign item.x_b         = s_tdata[23:16];
  assign item.y_b         = s_tdata[31:24];
  assign item.pixel_value = s_tdata[32];
  assign item.blit_width  = s_tdata[40:33];
  assign item.blit_height = s_tdata[48:41];
  assign item.blit_start  = s_tdata[49];
  assign item.byte_index  = s_tdata[58:50];

  pmfb_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  pmfb_blit u_blit (
    .clk     (clk),
    .rst     (rst),
    .step    (blit_step),
    .start   (item.blit_start),
    .width   (item.blit_width),
    .height  (item.blit_height),
    .col_off (col_off),
    .row_off (row_off)
  );

  pmfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .col_off   (col_off),
    .row_off   (row_off),
    .blit_step (blit_step),
    .req       (req),
    .rdata     (rdata),
    .out_free  (out_free),
    .res       (res)
  );

  // The output register is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte  <= res.data;
      out_index <= res.index;
    end
  end

  assign m_tdata = {7'd0, out_index, out_byte};

endmodule

/* rtl/pmfb_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the paged monochrome frame buffer, bound to its top level.
// Depends on pmfb_pkg and paged_mono_frame_buffer_core.
module pmfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // The clearing pass keeps the input closed right after reset.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open right after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // A command other than a read never produces a result word.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != pmfb_pkg::MODE_READ) && !m_tvalid
    |=> !m_tvalid)
    else $error("result word without a read");

  // A read beyond the store returns zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (int'(m_tdata[16:8]) >= pmfb_pkg::STORE_BYTES)
    |-> (m_tdata[7:0] == 8'd0))
    else $error("out-of-range read returned data");

endmodule

bind paged_mono_frame_buffer_core pmfb_checker u_pmfb_checker (.*);
